FILE: rtl/core/button_debounce_setpoint_stepper_top_assert.svh
// Assertion macros for the button debounce setpoint stepper.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef BUTTON_DEBOUNCE_SETPOINT_STEPPER_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_SETPOINT_STEPPER_TOP_ASSERT_SVH

// Checked only while out of reset
`define BDSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define BDSS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/bdss_pkg.sv
// Package for the button debounce setpoint stepper: widths, reset values,
// configuration register codes and the saturating step function. No dependencies.
`default_nettype none

package bdss_pkg;

  localparam int NumButtons = 4;
  localparam int CountW     = 8;
  localparam int SetpointW  = 16;
  localparam int StepW      = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  // Button positions in the level and event vectors
  localparam int BtnUp    = 0;
  localparam int BtnDown  = 1;
  localparam int BtnLeft  = 2;
  localparam int BtnRight = 3;

  // Reset values of the configuration registers
  localparam logic [CountW-1:0]           PollThresholdRst = 8'd3;
  localparam logic [NumButtons-1:0]       NormalLevelsRst  = 4'b1100;
  localparam logic [StepW-1:0]            HeightStepRst    = 8'd10;
  localparam logic signed [SetpointW-1:0] HeightLimitRst   = 16'sd100;
  localparam logic [StepW-1:0]            AngleStepRst     = 8'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLL_THRESHOLD = 3'd0,
    CFG_NORMAL_LEVELS  = 3'd1,
    CFG_HEIGHT_STEP    = 3'd2,
    CFG_HEIGHT_LIMIT   = 3'd3,
    CFG_ANGLE_STEP     = 3'd4
  } cfg_idx_e;

  // Add or subtract an unsigned step, clamping at the signed 16-bit limits
  function automatic logic signed [SetpointW-1:0] sat_step(
    input logic signed [SetpointW-1:0] value,
    input logic        [StepW-1:0]     step,
    input logic                        subtract
  );
    logic signed [SetpointW:0] ext;
    logic signed [SetpointW:0] stp;
    logic signed [SetpointW:0] sum;
    ext = {value[SetpointW-1], value};
    stp = $signed({{(SetpointW + 1 - StepW){1'b0}}, step});
    sum = subtract ? (ext - stp) : (ext + stp);
    if (sum[SetpointW] != sum[SetpointW-1]) begin
      sat_step = sum[SetpointW] ? {1'b1, {(SetpointW-1){1'b0}}}
                                : {1'b0, {(SetpointW-1){1'b1}}};
    end else begin
      sat_step = sum[SetpointW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bdss_in_if.sv
// Poll tick channel: valid/ready with the raw pin levels.
// Depends on bdss_pkg for the button count.
`default_nettype none

interface bdss_in_if;
  logic                             valid;
  logic                             ready;
  logic [bdss_pkg::NumButtons-1:0]  pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bdss_out_if.sv
// Result channel: valid/ready with setpoints, debounced levels and events.
// Depends on bdss_pkg for widths.
`default_nettype none

interface bdss_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bdss_pkg::SetpointW-1:0]  desired_height;
  logic signed [bdss_pkg::SetpointW-1:0]  desired_angle;
  logic        [bdss_pkg::NumButtons-1:0] debounced_levels;
  logic        [bdss_pkg::NumButtons-1:0] press_events;
  logic        [bdss_pkg::NumButtons-1:0] release_events;

  modport source (output valid, output desired_height, output desired_angle,
                  output debounced_levels, output press_events,
                  output release_events, input ready);
  modport sink   (input valid, input desired_height, input desired_angle,
                  input debounced_levels, input press_events,
                  input release_events, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/button_debounce_setpoint_stepper_top.sv
// Four-button debouncer that steps a height and an angle setpoint.
// Depends on bdss_pkg, bdss_in_if, bdss_out_if and the assertion macro header.
//
// Usage:
//   in_i carries one poll tick per transfer: the raw levels of the up, down,
//   left and right buttons. out_o returns exactly one result per tick: both
//   setpoints after the tick, the debounced levels and the press and release
//   events the tick caused.
//   The result of a tick accepted at one edge is registered and valid
//   after that edge. Throughput is one tick per cycle; it is set by the single
//   result register, which is refilled in the same cycle that it is drained.
//   When the receiver stalls, the result register holds and in_i.ready drops
//   until the result is taken; the debounce and setpoint state advance only
//   on an input transfer, so nothing is lost.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes one
//   register per cycle; writes are meant for idle periods. Unused indexes
//   are ignored.
//   Reset puts the registers at their default values, the debounced levels
//   at the default normal levels, counters and setpoints at zero, and
//   empties the result register.
`default_nettype none

`include "button_debounce_setpoint_stepper_top_assert.svh"

module button_debounce_setpoint_stepper_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bdss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bdss_pkg::CfgDataW-1:0] cfg_wdata_i,
  bdss_in_if.sink                            in_i,
  bdss_out_if.source                         out_o
);
  import bdss_pkg::*;

  // Configuration registers
  logic        [CountW-1:0]     poll_thr_q;
  logic        [NumButtons-1:0] normal_q;
  logic        [StepW-1:0]      height_step_q;
  logic signed [SetpointW-1:0]  height_limit_q;
  logic        [StepW-1:0]      angle_step_q;

  // Block state
  logic        [NumButtons-1:0] stable_q, stable_d;
  logic        [CountW-1:0]     cnt_q [NumButtons];
  logic        [CountW-1:0]     cnt_d [NumButtons];
  logic        [CountW:0]       cnt_inc [NumButtons];
  logic signed [SetpointW-1:0]  height_q, height_d, height_up;
  logic signed [SetpointW-1:0]  angle_q, angle_d, angle_rt;

  // Result register
  logic                         out_valid_q;
  logic        [NumButtons-1:0] press_q, press_d;
  logic        [NumButtons-1:0] release_q, release_d;

  logic                         in_xfer;
  logic        [CountW-1:0]     need;
  logic                         cnt_ok;

  // Accept whenever the result slot is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // A zero threshold acts as one
  assign need = (poll_thr_q == '0) ? CountW'(1) : poll_thr_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_thr_q     <= PollThresholdRst;
      normal_q       <= NormalLevelsRst;
      height_step_q  <= HeightStepRst;
      height_limit_q <= HeightLimitRst;
      angle_step_q   <= AngleStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLL_THRESHOLD: poll_thr_q     <= cfg_wdata_i[CountW-1:0];
        CFG_NORMAL_LEVELS:  normal_q       <= cfg_wdata_i[NumButtons-1:0];
        CFG_HEIGHT_STEP:    height_step_q  <= cfg_wdata_i[StepW-1:0];
        CFG_HEIGHT_LIMIT:   height_limit_q <= $signed(cfg_wdata_i[SetpointW-1:0]);
        CFG_ANGLE_STEP:     angle_step_q   <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Per-button debounce: run counter against the debounced level
  always_comb begin
    stable_d  = stable_q;
    press_d   = '0;
    release_d = '0;
    for (int i = 0; i < NumButtons; i++) begin
      cnt_inc[i] = {1'b0, cnt_q[i]} + (CountW + 1)'(1);
      cnt_d[i]   = '0;
      if (in_i.pin_levels[i] != stable_q[i]) begin
        if (cnt_inc[i] >= {1'b0, need}) begin
          stable_d[i] = in_i.pin_levels[i];
          if (in_i.pin_levels[i] != normal_q[i]) begin
            press_d[i] = 1'b1;
          end else begin
            release_d[i] = 1'b1;
          end
        end else begin
          cnt_d[i] = cnt_inc[i][CountW-1:0];
        end
      end
    end
  end

  // Setpoint steps: up then down on height, right then left on angle
  always_comb begin
    height_up = height_q;
    if (press_d[BtnUp] && (height_q < height_limit_q)) begin
      height_up = sat_step(height_q, height_step_q, 1'b0);
    end
    height_d = press_d[BtnDown] ? sat_step(height_up, height_step_q, 1'b1) : height_up;
    angle_rt = press_d[BtnRight] ? sat_step(angle_q, angle_step_q, 1'b0) : angle_q;
    angle_d  = press_d[BtnLeft] ? sat_step(angle_rt, angle_step_q, 1'b1) : angle_rt;
  end

  // State advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= NormalLevelsRst;
      height_q <= '0;
      angle_q  <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (in_xfer) begin
      stable_q <= stable_d;
      height_q <= height_d;
      angle_q  <= angle_d;
      for (int i = 0; i < NumButtons; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Event payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      press_q   <= press_d;
      release_q <= release_d;
    end
  end

  // Setpoints and levels are the state itself, which holds while stalled
  assign out_o.valid            = out_valid_q;
  assign out_o.desired_height   = height_q;
  assign out_o.desired_angle    = angle_q;
  assign out_o.debounced_levels = stable_q;
  assign out_o.press_events     = press_q;
  assign out_o.release_events   = release_q;

  // A run counter never reaches all ones: a count at the threshold flips the
  // level and clears, even after the threshold is lowered
  always_comb begin
    cnt_ok = 1'b1;
    for (int i = 0; i < NumButtons; i++) begin
      if (cnt_q[i] == '1) begin
        cnt_ok = 1'b0;
      end
    end
  end

  `BDSS_ASSERT(a_events_disjoint, out_valid_q |-> ((press_q & release_q) == '0), "press and release")
  `BDSS_ASSERT(a_ready_when_empty, !out_valid_q |-> in_i.ready, "input stalled while empty")
  `BDSS_ASSERT_ALWAYS(a_count_below_max, cnt_ok, "run counter saturated")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for button_debounce_setpoint_stepper_top: poll ticks in, setpoints out.
// A behavioral predictor runs beside the block; the bench needs bdss_pkg, bdss_in_if and bdss_out_if.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdss_pkg::*;

  localparam int CycleLimit = 400_000;
  // Index with no register behind it; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  localparam logic [NumButtons-1:0] UpLeftMask    = 4'(1 << BtnUp) | 4'(1 << BtnLeft);
  localparam logic [NumButtons-1:0] DownRightMask = 4'(1 << BtnDown) | 4'(1 << BtnRight);

  typedef struct packed {
    logic signed [SetpointW-1:0] height_sp;
    logic signed [SetpointW-1:0] angle_sp;
    logic        [NumButtons-1:0] levels;
    logic        [NumButtons-1:0] press_mask;
    logic        [NumButtons-1:0] release_mask;
  } poll_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic poll_valid = 1'b0;
  logic [NumButtons-1:0] poll_pins = '0;
  logic result_ready = 1'b0;

  bdss_in_if  in_if ();
  bdss_out_if out_if ();

  assign in_if.valid      = poll_valid;
  assign in_if.pin_levels = poll_pins;
  assign out_if.ready     = result_ready;

  button_debounce_setpoint_stepper_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the register file
  logic [CountW-1:0]           cfg_threshold = PollThresholdRst;
  logic [NumButtons-1:0]       cfg_normal    = NormalLevelsRst;
  logic [StepW-1:0]            cfg_hstep     = HeightStepRst;
  logic signed [SetpointW-1:0] cfg_hlimit    = HeightLimitRst;
  logic [StepW-1:0]            cfg_astep     = AngleStepRst;

  // Predictor state
  logic [NumButtons-1:0]       deb_level = NormalLevelsRst;
  logic [CountW-1:0]           disagree_run [NumButtons];
  logic signed [SetpointW-1:0] height_sp = '0;
  logic signed [SetpointW-1:0] angle_sp  = '0;

  logic [NumButtons-1:0] pending_pins [$];
  poll_result_t          expected_polls [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int polls_checked  = 0;
  int presses_seen   = 0;
  int clamp_hits     = 0;
  int settings_used  = 1;
  int cycle_count    = 0;

  initial begin
    for (int b = 0; b < NumButtons; b++) disagree_run[b] = '0;
  end

  function automatic logic signed [SetpointW-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SetpointW-1:0];
  endfunction

  // Advance the debounce and setpoint state by one poll and return the resulting outputs
  function automatic poll_result_t predict_poll(input logic [NumButtons-1:0] pins);
    poll_result_t r;
    int need;
    int b;
    int run;
    r = '0;
    need = (cfg_threshold == '0) ? 1 : int'(cfg_threshold);
    for (b = 0; b < NumButtons; b++) begin
      if (pins[b] != deb_level[b]) begin
        run = int'(disagree_run[b]) + 1;
        if (run >= need) begin
          deb_level[b] = pins[b];
          disagree_run[b] = '0;
          if (pins[b] != cfg_normal[b]) r.press_mask[b] = 1'b1;
          else r.release_mask[b] = 1'b1;
        end else begin
          disagree_run[b] = run[CountW-1:0];
        end
      end else begin
        disagree_run[b] = '0;
      end
    end
    // Up checks the limit against the height before this poll's down press
    if (r.press_mask[BtnUp] && height_sp < cfg_hlimit)
      height_sp = clamp16(int'(height_sp) + int'(cfg_hstep));
    if (r.press_mask[BtnDown])
      height_sp = clamp16(int'(height_sp) - int'(cfg_hstep));
    if (r.press_mask[BtnRight])
      angle_sp = clamp16(int'(angle_sp) + int'(cfg_astep));
    if (r.press_mask[BtnLeft])
      angle_sp = clamp16(int'(angle_sp) - int'(cfg_astep));
    r.height_sp = height_sp;
    r.angle_sp  = angle_sp;
    r.levels    = deb_level;
    return r;
  endfunction

  // Driver: next poll when the current one has transferred, random gaps and stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      poll_valid   <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if (!poll_valid || in_if.ready) begin
        if (pending_pins.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          poll_valid <= 1'b1;
          poll_pins  <= pending_pins.pop_front();
        end else begin
          poll_valid <= 1'b0;
        end
      end
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check result transfers, predict on poll transfers
  always @(posedge clk_i) begin
    poll_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_polls.size() == 0) begin
          $error("result transfer with no poll outstanding");
          mismatches++;
        end else begin
          want = expected_polls.pop_front();
          polls_checked++;
          if (out_if.desired_height !== want.height_sp) begin
            $error("desired_height: expected %0d, got %0d", want.height_sp,
                   out_if.desired_height);
            mismatches++;
          end
          if (out_if.desired_angle !== want.angle_sp) begin
            $error("desired_angle: expected %0d, got %0d", want.angle_sp,
                   out_if.desired_angle);
            mismatches++;
          end
          if (out_if.debounced_levels !== want.levels) begin
            $error("debounced_levels: expected %b, got %b", want.levels,
                   out_if.debounced_levels);
            mismatches++;
          end
          if (out_if.press_events !== want.press_mask) begin
            $error("press_events: expected %b, got %b", want.press_mask,
                   out_if.press_events);
            mismatches++;
          end
          if (out_if.release_events !== want.release_mask) begin
            $error("release_events: expected %b, got %b", want.release_mask,
                   out_if.release_events);
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = predict_poll(in_if.pin_levels);
        presses_seen += $countones(want.press_mask);
        if (want.height_sp == 16'sh7fff || want.height_sp == 16'sh8000 ||
            want.angle_sp == 16'sh7fff || want.angle_sp == 16'sh8000) clamp_hits++;
        expected_polls.push_back(want);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("button_debounce_setpoint_stepper_top regression: fail");
      $finish;
    end
  end

  // Block until every queued poll has transferred and every result came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_pins.size() != 0 || poll_valid || expected_polls.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLL_THRESHOLD: cfg_threshold = data[CountW-1:0];
      CFG_NORMAL_LEVELS:  cfg_normal    = data[NumButtons-1:0];
      CFG_HEIGHT_STEP:    cfg_hstep     = data[StepW-1:0];
      CFG_HEIGHT_LIMIT:   cfg_hlimit    = data;
      CFG_ANGLE_STEP:     cfg_astep     = data[StepW-1:0];
      default: ;
    endcase
  endtask

  // New register setting and idle pattern; unused upper data bits carry junk
  task automatic start_phase(input logic [CountW-1:0] thr, input logic [NumButtons-1:0] normal,
                             input logic [StepW-1:0] hstep, input logic signed [SetpointW-1:0] hlimit,
                             input logic [StepW-1:0] astep, input int send_pct, input int stall_pct);
    wait_drained();
    write_reg(CFG_POLL_THRESHOLD, {8'($urandom), thr});
    write_reg(CFG_NORMAL_LEVELS, {12'($urandom), normal});
    write_reg(CFG_HEIGHT_STEP, {8'($urandom), hstep});
    write_reg(CFG_HEIGHT_LIMIT, hlimit);
    write_reg(CFG_ANGLE_STEP, {8'($urandom), astep});
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    settings_used++;
  endtask

  task automatic queue_polls(input logic [NumButtons-1:0] seq [$]);
    foreach (seq[i]) pending_pins.push_back(seq[i]);
  endtask

  // Press and release of the buttons in mask, with contact bounce around both edges
  task automatic queue_gesture(input logic [NumButtons-1:0] mask, input int hold_extra,
                               input int bounce_max);
    int need;
    need = (cfg_threshold == '0) ? 1 : int'(cfg_threshold);
    repeat ($urandom_range(0, bounce_max))
      pending_pins.push_back(cfg_normal ^ (mask & 4'($urandom)));
    repeat (need + $urandom_range(0, hold_extra)) pending_pins.push_back(cfg_normal ^ mask);
    repeat ($urandom_range(0, bounce_max))
      pending_pins.push_back(cfg_normal ^ (mask & 4'($urandom)));
    repeat (need + $urandom_range(0, hold_extra)) pending_pins.push_back(cfg_normal);
  endtask

  // Mostly clean gestures, some held one poll short, some pure noise
  task automatic queue_activity(input int count);
    int kind;
    int need;
    logic [NumButtons-1:0] mask;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      mask = 4'($urandom_range(1, 15));
      need = (cfg_threshold == '0) ? 1 : int'(cfg_threshold);
      if (kind < 7) begin
        queue_gesture(mask, 2, 3);
      end else if (kind < 9) begin
        repeat (need - 1) pending_pins.push_back(cfg_normal ^ mask);
        pending_pins.push_back(cfg_normal);
      end else begin
        repeat ($urandom_range(1, 6)) pending_pins.push_back(4'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: simultaneous left/right press, near miss, up and down together
    queue_polls('{4'b0000, 4'b0000, 4'b0000, 4'b1111, 4'b1111, 4'b0000,
                  4'b1111, 4'b1111, 4'b1111, 4'b1100, 4'b1100, 4'b1100});

    // Zero threshold acts as one; new normal levels turn held buttons into releases
    start_phase(8'd0, 4'b1111, 8'd255, 16'sd100, 8'd255, 0, 0);
    write_reg(CfgIdxSpare, 16'($urandom));
    queue_polls('{4'b1111, 4'b0101, 4'b1111, 4'b0000, 4'b1111});

    // Height limit blocks up; up and down in one poll see the old height
    start_phase(8'd0, 4'b1111, 8'd255, -16'sd300, 8'd255, 0, 0);
    queue_polls('{4'b1110, 4'b1111, 4'b1100, 4'b1111, 4'b1100, 4'b1111, 4'b1110, 4'b1111});

    // Zero steps, lowest limit, all-zero normal levels
    start_phase(8'd2, 4'b0000, 8'd0, -16'sd32768, 8'd0, 60, 0);
    queue_activity(12);

    start_phase(8'($urandom_range(1, 5)), 4'($urandom), 8'($urandom), 16'($urandom),
                8'($urandom), 0, 60);
    queue_activity(12);

    // Drive height to the top clamp and angle to the bottom clamp
    start_phase(8'd1, 4'($urandom), 8'd255, 16'sd32767, 8'd255, 34, 34);
    repeat (150) queue_gesture(UpLeftMask, 1, 0);

    start_phase(8'd4, 4'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 0, 0);
    queue_activity(12);

    // And across to the opposite clamps
    start_phase(8'd1, 4'($urandom), 8'd255, 16'sd32767, 8'd255, 0, 60);
    repeat (275) queue_gesture(DownRightMask, 1, 0);

    // Longest debounce run
    start_phase(8'd255, 4'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 60, 0);
    queue_gesture(4'($urandom_range(1, 15)), 2, 3);

    start_phase(8'd3, 4'($urandom), 8'($urandom), 16'sh8000, 8'($urandom), 34, 34);
    queue_activity(15);

    wait_drained();
    $display("Checked %0d poll results over %0d register settings: %0d presses, %0d at a clamp.",
             polls_checked, settings_used, presses_seen, clamp_hits);
    if (mismatches == 0) begin
      $display("button_debounce_setpoint_stepper_top regression: pass");
    end else begin
      $display("button_debounce_setpoint_stepper_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
